// ===== design/leb_pkg.sv =====
// Shared types and constants for the line edit buffer.
package leb_pkg;

    localparam int CAPACITY = 64;
    localparam int PTR_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int IDX_W    = 6;
    localparam int CMP_W    = (PTR_W > IDX_W) ? PTR_W : IDX_W;
    localparam int SUM_W    = ((PTR_W > 8) ? PTR_W : 8) + 2;

    typedef enum logic [2:0] {
        OP_INSERT    = 3'd0,
        OP_BACKSPACE = 3'd1,
        OP_DELETE    = 3'd2,
        OP_MOVE      = 3'd3,
        OP_HOME      = 3'd4,
        OP_END       = 3'd5,
        OP_CLEAR     = 3'd6,
        OP_READ      = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        SH_HOLD  = 2'd0,
        SH_RIGHT = 2'd1,
        SH_LEFT  = 2'd2
    } t_shift;

    typedef enum logic [1:0] {
        RD_HOLD  = 2'd0,
        RD_LOAD  = 2'd1,
        RD_SHIFT = 2'd2
    } t_rdop;

    typedef struct packed {
        t_shift           shift;
        logic [PTR_W-1:0] base;
        logic [7:0]       chr;
        t_rdop            rd;
    } t_cell_cmd;

endpackage

// ===== design/leb_cell.sv =====
// One byte cell of the buffer chain with its read-out shift stage.
module leb_cell
    import leb_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_cmd        i_cmd,
    input  logic [PTR_W-1:0] i_index,
    input  logic [7:0]       i_left,
    input  logic [7:0]       i_right,
    input  logic [7:0]       i_rd_right,
    output logic [7:0]       o_data,
    output logic [7:0]       o_rd
);

    logic [7:0] r_data;
    logic [7:0] r_rd;
    logic [7:0] n_data;
    logic [7:0] n_rd;

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.shift)
            SH_RIGHT: begin
                if (i_index > i_cmd.base) begin
                    n_data = i_left;
                end else if (i_index == i_cmd.base) begin
                    n_data = i_cmd.chr;
                end
            end
            SH_LEFT: begin
                if (i_index >= i_cmd.base) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase

        n_rd = r_rd;
        unique case (i_cmd.rd)
            RD_LOAD:  n_rd = r_data;
            RD_SHIFT: n_rd = i_rd_right;
            default:  n_rd = r_rd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_rd   <= n_rd;
    end

    assign o_data = r_data;
    assign o_rd   = r_rd;

endmodule

// ===== design/leb_ctrl.sv =====
// Length, cursor and handshake control for the line edit buffer.
module leb_ctrl
    import leb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_opcode,
    input  logic [7:0]        i_char_in,
    input  logic signed [7:0] i_move_delta,
    input  logic [IDX_W-1:0]  i_read_index,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_status,
    output logic [IDX_W-1:0]  o_text_length,
    output logic [IDX_W-1:0]  o_cursor_pos,
    output logic [7:0]        o_read_char,
    input  logic [7:0]        i_rd_head,
    output t_cell_cmd         o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_len, n_len;
    logic [PTR_W-1:0] r_cur, n_cur;
    logic [PTR_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             r_status, n_status;
    logic [7:0]       r_char, n_char;
    logic [IDX_W-1:0] r_len_o;
    logic [IDX_W-1:0] r_cur_o;

    logic                    accept;
    logic                    out_free;
    logic                    res_fire;
    t_op                     op;
    logic [CMP_W-1:0]        ridx_x;
    logic [CMP_W-1:0]        len_x;
    logic signed [SUM_W-1:0] mv_sum;
    logic signed [SUM_W-1:0] len_s;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign op         = t_op'(i_opcode);
    assign ridx_x     = CMP_W'(i_read_index);
    assign len_x      = CMP_W'(r_len);
    assign mv_sum     = SUM_W'($signed({1'b0, r_cur})) + SUM_W'(i_move_delta);
    assign len_s      = SUM_W'($signed({1'b0, r_len}));

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_cur     = r_cur;
        n_cnt     = r_cnt;
        n_status  = r_status;
        n_char    = r_char;
        res_fire  = 1'b0;
        o_cmd     = '{shift: SH_HOLD, base: r_cur, chr: i_char_in, rd: RD_HOLD};

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    res_fire = 1'b1;
                    n_status = 1'b0;
                    n_char   = 8'd0;
                    unique case (op)
                        OP_INSERT: begin
                            if (r_len >= PTR_W'(CAPACITY - 1)) begin
                                n_status = 1'b1;
                            end else begin
                                o_cmd.shift = SH_RIGHT;
                                n_len       = r_len + 1'b1;
                                n_cur       = r_cur + 1'b1;
                            end
                        end
                        OP_BACKSPACE: begin
                            if (r_cur != '0) begin
                                o_cmd.shift = SH_LEFT;
                                o_cmd.base  = r_cur - 1'b1;
                                n_len       = r_len - 1'b1;
                                n_cur       = r_cur - 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            if (r_cur < r_len) begin
                                o_cmd.shift = SH_LEFT;
                                n_len       = r_len - 1'b1;
                            end
                        end
                        OP_MOVE: begin
                            if (mv_sum < 0) begin
                                n_cur = '0;
                            end else if (mv_sum > len_s) begin
                                n_cur = r_len;
                            end else begin
                                n_cur = PTR_W'(mv_sum);
                            end
                        end
                        OP_HOME:  n_cur = '0;
                        OP_END:   n_cur = r_len;
                        OP_CLEAR: begin
                            n_len = '0;
                            n_cur = '0;
                        end
                        OP_READ: begin
                            if (ridx_x < len_x) begin
                                res_fire = 1'b0;
                                o_cmd.rd = RD_LOAD;
                                n_cnt    = PTR_W'(ridx_x);
                                n_state  = ST_READ;
                            end
                        end
                        default: n_status = 1'b0;
                    endcase
                end
            end
            ST_READ: begin
                if (r_cnt != '0) begin
                    o_cmd.rd = RD_SHIFT;
                    n_cnt    = r_cnt - 1'b1;
                end else if (out_free) begin
                    res_fire = 1'b1;
                    n_status = 1'b0;
                    n_char   = i_rd_head;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (res_fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_cur       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_cur       <= n_cur;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_status <= n_status;
        r_char   <= n_char;
        if (res_fire) begin
            r_len_o <= IDX_W'(n_len);
            r_cur_o <= IDX_W'(n_cur);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_text_length = r_len_o;
    assign o_cursor_pos  = r_cur_o;
    assign o_read_char   = r_char;

endmodule

// ===== design/line_edit_buffer.sv =====
// Line edit buffer top level: control and a row of byte cells.
//
// Usage: one edit command per input beat (opcode, char_in, move_delta,
// read_index) on the i_in_valid / o_in_stall channel; one result beat per
// command (status, text_length, cursor_pos, read_char) on o_out_valid /
// i_out_stall. A beat moves at a clock edge with valid high and stall low.
// Insert, backspace and delete shift the stored bytes one place: every
// cell from the edit point on takes its neighbor or the new byte at once.
// The result is registered in the cycle after acceptance for all commands
// except an in-range read. A read at index k loads every cell's byte into
// a read-out chain, shifts it toward cell 0 k times and registers the head
// byte once the result register is free; an out-of-range read is answered
// like the other commands. Throughput: one command per cycle for all but
// in-range reads, and none while a read shifts out; a new command is taken
// while the result register is free or being emptied.
// Reset (synchronous, active low) empties the buffer and clears the cursor
// and the result valid flag. When the receiver stalls, the result holds and
// o_in_stall rises until the result is taken.
module line_edit_buffer
    import leb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_opcode,
    input  logic [7:0]        i_char_in,
    input  logic signed [7:0] i_move_delta,
    input  logic [IDX_W-1:0]  i_read_index,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_status,
    output logic [IDX_W-1:0]  o_text_length,
    output logic [IDX_W-1:0]  o_cursor_pos,
    output logic [7:0]        o_read_char
);

    t_cell_cmd  cmd;
    logic [7:0] cell_data [CAPACITY];
    logic [7:0] cell_rd   [CAPACITY];

    leb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_char_in     (i_char_in),
        .i_move_delta  (i_move_delta),
        .i_read_index  (i_read_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_text_length (o_text_length),
        .o_cursor_pos  (o_cursor_pos),
        .o_read_char   (o_read_char),
        .i_rd_head     (cell_rd[0]),
        .o_cmd         (cmd)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [7:0] left_v;
        logic [7:0] right_v;
        logic [7:0] rd_right_v;

        if (g == 0) begin : g_first
            assign left_v = 8'd0;
        end else begin : g_mid_l
            assign left_v = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_v    = 8'd0;
            assign rd_right_v = 8'd0;
        end else begin : g_mid_r
            assign right_v    = cell_data[g+1];
            assign rd_right_v = cell_rd[g+1];
        end

        leb_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cmd),
            .i_index    (PTR_W'(g)),
            .i_left     (left_v),
            .i_right    (right_v),
            .i_rd_right (rd_right_v),
            .o_data     (cell_data[g]),
            .o_rd       (cell_rd[g])
        );
    end

endmodule

// ===== design/leb_chk.sv =====
// Port-level checks for the line edit buffer, bound to the top level.
module leb_chk
    import leb_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic             o_status,
    input logic [IDX_W-1:0] o_text_length,
    input logic [IDX_W-1:0] o_cursor_pos,
    input logic [7:0]       o_read_char
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_text_length)
            && $stable(o_cursor_pos) && $stable(o_read_char) && $stable(o_status))
        else $error("result changed while stalled");

    a_cur_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cursor_pos <= o_text_length)
        else $error("cursor beyond length");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_read_char == 8'd0
            && o_text_length == IDX_W'(CAPACITY - 1))
        else $error("full status with bad fields");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while result is stalled");

endmodule

bind line_edit_buffer leb_chk u_leb_chk (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for line_edit_buffer: random edit traffic against a cycle-free predictor.
module tb_top;
    import leb_pkg::*;

    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BEATS   = 400;
    localparam int DRAIN_CYCLES   = 80;

    typedef struct packed {
        logic             status;
        logic [IDX_W-1:0] len;
        logic [IDX_W-1:0] cur;
        logic [7:0]       rchar;
    } edit_result_t;

    typedef enum int {EP_TYPE, EP_FILL, EP_EDIT, EP_NAV} episode_e;

    class edit_scoreboard;
        logic [7:0]   text [CAPACITY];
        int           text_len;
        int           cursor;
        edit_result_t want_q [$];
        int           errors;
        int           n_checked;
        int           n_full;
        int           n_hits;

        function new();
            foreach (text[i]) text[i] = 8'h00;
            text_len  = 0;
            cursor    = 0;
            errors    = 0;
            n_checked = 0;
            n_full    = 0;
            n_hits    = 0;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function void note_command(t_op op, logic [7:0] ch, logic signed [7:0] delta,
                                   logic [IDX_W-1:0] idx);
            edit_result_t r;
            int step;
            r = '0;
            step = int'(delta);
            case (op)
                OP_INSERT: begin
                    if (text_len + 1 >= CAPACITY) begin
                        r.status = 1'b1;
                        n_full++;
                    end else begin
                        for (int i = text_len; i > cursor; i--) text[i] = text[i-1];
                        text[cursor] = ch;
                        text_len++;
                        cursor++;
                    end
                end
                OP_BACKSPACE: begin
                    if (cursor != 0) begin
                        for (int i = cursor; i < text_len; i++) text[i-1] = text[i];
                        text_len--;
                        cursor--;
                    end
                end
                OP_DELETE: begin
                    if (cursor < text_len) begin
                        for (int i = cursor; i + 1 < text_len; i++) text[i] = text[i+1];
                        text_len--;
                    end
                end
                OP_MOVE: begin
                    if (step < 0)
                        cursor = (-step >= cursor) ? 0 : cursor + step;
                    else
                        cursor = (step >= text_len - cursor) ? text_len : cursor + step;
                end
                OP_HOME:  cursor = 0;
                OP_END:   cursor = text_len;
                OP_CLEAR: begin
                    text_len = 0;
                    cursor   = 0;
                end
                OP_READ: begin
                    if (int'(idx) < text_len) begin
                        r.rchar = text[idx];
                        n_hits++;
                    end
                end
            endcase
            r.len = IDX_W'(text_len);
            r.cur = IDX_W'(cursor);
            want_q.push_back(r);
        endfunction

        task report(string what);
            $display("tb_top: mismatch: %s", what);
            errors++;
        endtask

        task check_result(edit_result_t got);
            edit_result_t w;
            if (want_q.size() == 0) begin
                report($sformatf("result beat with no command pending (len %0d cursor %0d)",
                                 got.len, got.cur));
                return;
            end
            w = want_q.pop_front();
            n_checked++;
            if (got.status !== w.status)
                report($sformatf("beat %0d status %0b, want %0b", n_checked, got.status,
                                 w.status));
            if (got.len !== w.len)
                report($sformatf("beat %0d text_length %0d, want %0d", n_checked, got.len,
                                 w.len));
            if (got.cur !== w.cur)
                report($sformatf("beat %0d cursor_pos %0d, want %0d", n_checked, got.cur,
                                 w.cur));
            if (got.rchar !== w.rchar)
                report($sformatf("beat %0d read_char %02h, want %02h", n_checked, got.rchar,
                                 w.rchar));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_stall;
    logic [2:0]        i_opcode     = '0;
    logic [7:0]        i_char_in    = '0;
    logic signed [7:0] i_move_delta = '0;
    logic [IDX_W-1:0]  i_read_index = '0;
    logic              o_out_valid;
    logic              i_out_stall  = 1'b0;
    logic              o_status;
    logic [IDX_W-1:0]  o_text_length;
    logic [IDX_W-1:0]  o_cursor_pos;
    logic [7:0]        o_read_char;

    edit_scoreboard sb;
    int             burst_left   = 0;
    int             quiet_cycles = 0;
    bit             drain_done   = 1'b0;

    line_edit_buffer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_char_in     (i_char_in),
        .i_move_delta  (i_move_delta),
        .i_read_index  (i_read_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_text_length (o_text_length),
        .o_cursor_pos  (o_cursor_pos),
        .o_read_char   (o_read_char)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // offer one command beat; bursts of random length with idle gaps, sometimes none, between them
    task automatic offer(t_op op, logic [7:0] ch, logic signed [7:0] delta,
                         logic [IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_char_in    <= ch;
        i_move_delta <= delta;
        i_read_index <= idx;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_command(t_op'(i_opcode), i_char_in, i_move_delta, i_read_index);
            if (o_out_valid && !i_out_stall)
                sb.check_result('{o_status, o_text_length, o_cursor_pos, o_read_char});
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top: no beat moved for %0d cycles", quiet_cycles);
                $display("tb_top: errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // result side: varied stall patterns, one long hold-off to back the block up
    initial begin
        int  mode;
        int  span;
        int  elapsed;
        bit  held;
        elapsed = 0;
        held    = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        while (!drain_done) begin
            if (!held && elapsed >= 120) begin
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(10, 60);
                for (int k = 0; k < span; k++) begin
                    case (mode)
                        0: i_out_stall <= 1'b0;
                        1: i_out_stall <= 1'($urandom_range(0, 1));
                        2: i_out_stall <= ((k % 4) == 3);
                        default: i_out_stall <= ($urandom_range(0, 9) == 0);
                    endcase
                    @(posedge i_clk);
                    elapsed++;
                end
            end
        end
        i_out_stall <= 1'b0;
    end

    initial begin
        int                n_sent;
        int                r;
        int                span;
        episode_e          kind;
        t_op               op;
        logic [7:0]        ch;
        logic signed [7:0] dl;
        logic [IDX_W-1:0]  ix;

        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty-line corners, shifts in the middle, clamped moves, clear
        offer(OP_READ,      8'h3c, 8'sh11, 6'd0);
        offer(OP_BACKSPACE, 8'hc3, 8'sh22, 6'd63);
        offer(OP_DELETE,    8'h00, 8'sh33, 6'd21);
        offer(OP_MOVE,      8'hff, -8'sd128, 6'd42);
        offer(OP_MOVE,      8'h00, 8'sd127, 6'd0);
        offer(OP_INSERT,    8'hff, 8'sh00, 6'd63);
        offer(OP_INSERT,    8'h00, 8'sh7f, 6'd0);
        offer(OP_INSERT,    8'h5a, -8'sd1, 6'd31);
        offer(OP_MOVE,      8'ha5, -8'sd2, 6'd32);
        offer(OP_INSERT,    8'ha5, 8'sh55, 6'd1);
        offer(OP_READ,      8'h00, 8'sh00, 6'd0);
        offer(OP_READ,      8'h00, 8'sh00, 6'd1);
        offer(OP_READ,      8'h00, 8'sh00, 6'd3);
        offer(OP_READ,      8'hff, -8'sd1, 6'd63);
        offer(OP_HOME,      8'h81, 8'sh2a, 6'd5);
        offer(OP_BACKSPACE, 8'h7e, -8'sd43, 6'd10);
        offer(OP_DELETE,    8'h18, 8'sh0c, 6'd20);
        offer(OP_END,       8'he7, -8'sd7, 6'd40);
        offer(OP_DELETE,    8'h42, 8'sh3f, 6'd50);
        offer(OP_MOVE,      8'h24, -8'sd128, 6'd15);
        offer(OP_MOVE,      8'hdb, 8'sd127, 6'd48);
        offer(OP_BACKSPACE, 8'h99, 8'sh66, 6'd2);
        offer(OP_CLEAR,     8'h66, -8'sd103, 6'd61);
        offer(OP_READ,      8'h00, 8'sh00, 6'd0);
        offer(OP_INSERT,    8'h3c, 8'sh01, 6'd0);

        n_sent = 0;
        kind   = EP_FILL;
        while (n_sent < RANDOM_BEATS) begin
            span = (kind == EP_FILL) ? 70 : $urandom_range(10, 40);
            repeat (span) begin
                r = $urandom_range(0, 99);
                case (kind)
                    EP_TYPE: op = (r < 70) ? OP_INSERT : (r < 80) ? OP_MOVE :
                                  (r < 90) ? OP_READ : (r < 95) ? OP_BACKSPACE : OP_DELETE;
                    EP_FILL: op = (r < 85) ? OP_INSERT : OP_READ;
                    EP_EDIT: begin
                        op = t_op'($urandom_range(0, 7));
                        if (op == OP_CLEAR && r >= 40)
                            op = OP_READ;
                    end
                    default: op = (r < 40) ? OP_MOVE : (r < 50) ? OP_HOME :
                                  (r < 60) ? OP_END : (r < 85) ? OP_READ :
                                  (r < 93) ? OP_DELETE : OP_BACKSPACE;
                endcase
                ch = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 1)
                    dl = 8'($urandom_range(0, 255));
                else
                    dl = 8'($urandom_range(0, 10) - 5);
                if (sb.text_len > 0 && $urandom_range(0, 3) != 0)
                    ix = IDX_W'($urandom_range(0, sb.text_len - 1));
                else
                    ix = IDX_W'($urandom_range(0, 63));
                offer(op, ch, dl, ix);
                n_sent++;
            end
            kind = episode_e'($urandom_range(0, 3));
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        drain_done = 1'b1;

        $display("tb_top: %0d results checked, %0d full-line inserts refused, %0d reads hit",
                 sb.n_checked, sb.n_full, sb.n_hits);
        $display("tb_top: sender bursts, varied result stalls and one %0d-cycle hold-off exercised",
                 HOLD_CYCLES);
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
